>>> design/icfm_pkg.sv
// Package for the input capture frequency meter.
// Widths, reset values and shared types. No dependencies.
`default_nettype none
package icfm_pkg;

  localparam int COUNTER_WIDTH = 16;
  localparam int REF_WIDTH     = 24;
  localparam int PERIOD_WIDTH  = 16;
  localparam int DIV_STEPS     = REF_WIDTH;
  localparam int ITER_WIDTH    = $clog2(DIV_STEPS);

  localparam logic [REF_WIDTH-1:0]  REF_RESET = 24'd8000000;
  localparam logic [ITER_WIDTH-1:0] ITER_LAST = ITER_WIDTH'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    PH_RISE  = 3'b001,
    PH_FALL  = 3'b010,
    PH_CLOSE = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  typedef struct packed {
    logic tick;
    logic capture_start;
    logic close;
    logic div_start;
    logic div_step;
  } icfm_cmd_t;

  typedef struct packed {
    logic rising;
    logic falling;
    logic greater;
    logic prev_level;
    logic div_last;
  } icfm_status_t;

endpackage
`default_nettype wire

>>> design/icfm_if.sv
// Handshake interfaces: tick input, result output, configuration write.
// Depends on icfm_pkg.
`default_nettype none
interface icfm_tick_if;
  logic valid;
  logic ready;
  logic signal_level;
  modport source (output valid, output signal_level, input ready);
  modport sink   (input valid, input signal_level, output ready);
endinterface

interface icfm_result_if import icfm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [REF_WIDTH-1:0]    frequency_hz;
  logic [PERIOD_WIDTH-1:0] period_ticks;
  modport source (output valid, output frequency_hz, output period_ticks, input ready);
  modport sink   (input valid, input frequency_hz, input period_ticks, output ready);
endinterface

interface icfm_cfg_if import icfm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [REF_WIDTH-1:0] reference_hz;
  modport source (output valid, output reference_hz, input ready);
  modport sink   (input valid, input reference_hz, output ready);
endinterface
`default_nettype wire

>>> design/icfm_ctrl.sv
// Controller: capture phase machine and divider sequencer.
// Depends on icfm_pkg.
`default_nettype none
module icfm_ctrl import icfm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire icfm_status_t status,
  output icfm_cmd_t         cmd
);

  phase_t     phase, phase_next;
  div_state_t div_state, div_state_next;
  logic       tick;

  // A closing edge could need the divider; hold ticks off while it is in use.
  assign in_ready = !((phase == PH_CLOSE) && !status.prev_level && (div_state != DIV_IDLE));
  assign tick     = in_valid && in_ready;
  assign out_valid = (div_state == DIV_DONE);

  always_comb begin
    phase_next        = phase;
    div_state_next    = div_state;
    cmd               = '0;
    cmd.tick          = tick;
    case (phase)
      PH_RISE: begin
        if (tick && status.rising) begin
          cmd.capture_start = 1'b1;
          phase_next        = PH_FALL;
        end
      end
      PH_FALL: begin
        if (tick && status.falling) phase_next = PH_CLOSE;
      end
      PH_CLOSE: begin
        if (tick && status.rising) begin
          cmd.close     = 1'b1;
          cmd.div_start = status.greater;
          phase_next    = PH_RISE;
        end
      end
      default: phase_next = PH_RISE;
    endcase
    case (div_state)
      DIV_IDLE: begin
        if (cmd.div_start) div_state_next = DIV_RUN;
      end
      DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) div_state_next = DIV_DONE;
      end
      DIV_DONE: begin
        if (out_ready) div_state_next = DIV_IDLE;
      end
      default: div_state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_RISE;
      div_state <= DIV_IDLE;
    end else begin
      phase     <= phase_next;
      div_state <= div_state_next;
    end
  end

endmodule
`default_nettype wire

>>> design/icfm_datapath.sv
// Datapath: tick counter, edge detect, start capture, serial divider.
// Depends on icfm_pkg.
`default_nettype none
module icfm_datapath import icfm_pkg::*; #(
  parameter int CW = COUNTER_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 level,
  input  wire logic                 cfg_we,
  input  wire logic [REF_WIDTH-1:0] cfg_data,
  input  wire icfm_cmd_t            cmd,
  output icfm_status_t              status,
  output logic [REF_WIDTH-1:0]      frequency_hz,
  output logic [PERIOD_WIDTH-1:0]   period_ticks
);

  logic [REF_WIDTH-1:0]  reference_hz;
  logic [CW-1:0]         tick_counter;
  logic [CW-1:0]         start_capture;
  logic                  prev_level;
  logic [CW-1:0]         divisor;
  logic [CW-1:0]         rem;
  logic [REF_WIDTH-1:0]  quo;
  logic [ITER_WIDTH-1:0] iter;
  logic [CW:0]           trial;
  logic [CW:0]           diff;
  logic                  fits;

  assign status.rising     = !prev_level && level;
  assign status.falling    = prev_level && !level;
  assign status.greater    = tick_counter > start_capture;
  assign status.prev_level = prev_level;
  assign status.div_last   = (iter == ITER_LAST);

  assign trial = {rem, quo[REF_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = !diff[CW];

  assign frequency_hz = quo;
  assign period_ticks = PERIOD_WIDTH'(divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_hz  <= REF_RESET;
      tick_counter  <= '0;
      start_capture <= '0;
      prev_level    <= 1'b0;
    end else begin
      if (cfg_we) reference_hz <= cfg_data;
      if (cmd.tick) begin
        prev_level   <= level;
        tick_counter <= cmd.close ? '0 : tick_counter + 1'b1;
      end
      if (cmd.capture_start) start_capture <= tick_counter;
    end
  end

  // Restoring division, one quotient bit per cycle shifted in behind the numerator.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      divisor <= tick_counter - start_capture;
      quo     <= reference_hz;
      rem     <= '0;
      iter    <= '0;
    end else if (cmd.div_step) begin
      rem  <= fits ? diff[CW-1:0] : trial[CW-1:0];
      quo  <= {quo[REF_WIDTH-2:0], fits};
      iter <= iter + 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> design/input_capture_frequency_meter_top.sv
// Input capture reciprocal frequency meter, top level.
// One tick per cycle unless stalled. A closing edge with a count above the
// start capture loads the divisor; the serial divider runs 24 steps and
// holds the result until taken. Ticks stall only when a closing edge could
// arrive while the divider or output register is busy. Synchronous reset
// clears the capture state and counter and sets reference_hz to 8000000.
`default_nettype none
module input_capture_frequency_meter_top import icfm_pkg::*; #(
  parameter int CW = COUNTER_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst,
  icfm_tick_if.sink     tick,
  icfm_result_if.source result,
  icfm_cfg_if.sink      cfg
);

  icfm_cmd_t    cmd;
  icfm_status_t status;

  assign cfg.ready = 1'b1;

  icfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  icfm_datapath #(.CW(CW)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .level        (tick.signal_level),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.reference_hz),
    .cmd          (cmd),
    .status       (status),
    .frequency_hz (result.frequency_hz),
    .period_ticks (result.period_ticks)
  );

endmodule
`default_nettype wire

>>> dv/input_capture_frequency_meter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the input capture frequency meter: follows tick and config
// transfers, predicts each period/frequency result and checks result transfers.
// Depends on icfm_pkg and the channel interfaces in icfm_if.sv.
module input_capture_frequency_meter_checker import icfm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  icfm_tick_if   tick,
  icfm_result_if result,
  icfm_cfg_if    cfg,
  output int     errors,
  output int     outstanding,
  output int     taken
);

  typedef struct packed {
    logic [REF_WIDTH-1:0]    freq;
    logic [PERIOD_WIDTH-1:0] period;
  } meas_t;

  meas_t measq[$];

  logic [REF_WIDTH-1:0]     ref_hz;
  logic [COUNTER_WIDTH-1:0] count;
  logic [COUNTER_WIDTH-1:0] start_cnt;
  phase_t                   phase;
  logic                     prev_lvl;
  int                       err_cnt = 0;
  int                       res_cnt = 0;

  function automatic void advance_meter(input logic lvl);
    logic                     rising;
    logic                     falling;
    logic                     closed;
    logic [COUNTER_WIDTH-1:0] now;
    logic [COUNTER_WIDTH-1:0] span;
    meas_t                    m;
    rising   = !prev_lvl && lvl;
    falling  = prev_lvl && !lvl;
    now      = count;
    closed   = 1'b0;
    prev_lvl = lvl;
    case (phase)
      PH_FALL: begin
        if (falling) phase = PH_CLOSE;
      end
      PH_CLOSE: begin
        if (rising) begin
          if (now > start_cnt) begin
            span     = now - start_cnt;
            m.freq   = REF_WIDTH'(ref_hz / span);
            m.period = PERIOD_WIDTH'(span);
            measq.push_back(m);
          end
          closed = 1'b1;
        end
      end
      default: begin
        if (rising) begin
          start_cnt = now;
          phase     = PH_FALL;
        end else begin
          phase = PH_RISE;
        end
      end
    endcase
    if (closed) begin
      count = '0;
      phase = PH_RISE;
    end else begin
      count = now + 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    meas_t exp_m;
    if (rst) begin
      measq.delete();
      ref_hz    = REF_RESET;
      count     = '0;
      start_cnt = '0;
      phase     = PH_RISE;
      prev_lvl  = 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        res_cnt++;
        if (measq.size() == 0) begin
          $error("unexpected result transfer: frequency_hz %0d period_ticks %0d",
                 result.frequency_hz, result.period_ticks);
          err_cnt++;
        end else begin
          exp_m = measq.pop_front();
          if (result.frequency_hz !== exp_m.freq) begin
            $error("frequency_hz mismatch: expected %0d, actual %0d",
                   exp_m.freq, result.frequency_hz);
            err_cnt++;
          end
          if (result.period_ticks !== exp_m.period) begin
            $error("period_ticks mismatch: expected %0d, actual %0d",
                   exp_m.period, result.period_ticks);
            err_cnt++;
          end
        end
      end
      if (cfg.valid && cfg.ready) ref_hz = cfg.reference_hz;
      if (tick.valid && tick.ready) advance_meter(tick.signal_level);
    end
    errors      <= err_cnt;
    outstanding <= measq.size();
    taken       <= res_cnt;
  end

endmodule

>>> dv/input_capture_frequency_meter_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the input capture frequency meter: drives ticks, config
// writes and result back-pressure; the checker module predicts and compares.
// Depends on icfm_pkg, icfm_if.sv, the meter RTL and the checker module.
module input_capture_frequency_meter_top_tb;
  import icfm_pkg::*;

  localparam int LIMIT = 2_000_000;
  localparam int DRAIN = 40;

  logic clk = 1'b0;
  logic rst;
  bit   idle_on = 1'b0;
  int   cycles = 0;
  int   ticks_sent = 0;
  int   res_hold = 0;
  int   res_draw;
  int   errors;
  int   outstanding;
  int   taken;

  icfm_tick_if   tick_if ();
  icfm_result_if res_if ();
  icfm_cfg_if    cfg_if ();

  input_capture_frequency_meter_top dut (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  input_capture_frequency_meter_checker u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick_if),
    .result      (res_if),
    .cfg         (cfg_if),
    .errors      (errors),
    .outstanding (outstanding),
    .taken       (taken)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("input_capture_frequency_meter_top_tb: FAIL");
      $finish;
    end
  end

  // result back-pressure: random hold-off after each transfer while idle_on is set
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      res_hold     <= 0;
    end else if (res_if.valid && res_if.ready) begin
      res_draw = idle_on ? $urandom_range(0, 4) : 0;
      res_hold     <= res_draw;
      res_if.ready <= (res_draw == 0);
    end else if (res_hold > 0) begin
      res_hold     <= res_hold - 1;
      res_if.ready <= (res_hold == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic send_tick(input logic lvl);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      tick_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_if.valid        <= 1'b1;
    tick_if.signal_level <= lvl;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // low lead-in, high run, low run, then the closing rising edge
  task automatic run_measurement(input int pre, input int hi, input int lo);
    repeat (pre) send_tick(1'b0);
    repeat (hi) send_tick(1'b1);
    repeat (lo) send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic settle();
    tick_if.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_ref(input logic [REF_WIDTH-1:0] val);
    cfg_if.valid        <= 1'b1;
    cfg_if.reference_hz <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_traffic(input int min_ticks, input int min_results);
    int t0;
    int r0;
    int hi;
    int lo;
    t0 = ticks_sent;
    r0 = taken;
    while ((ticks_sent - t0) < min_ticks || (taken - r0) < min_results) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 10)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          hi = $urandom_range(1, 100);
          lo = $urandom_range(1, 100);
        end else begin
          hi = $urandom_range(1, 12);
          lo = $urandom_range(1, 12);
        end
        run_measurement($urandom_range(1, 6), hi, lo);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    logic [REF_WIDTH-1:0] ref_vals[6];
    rst                 <= 1'b1;
    tick_if.valid       <= 1'b0;
    tick_if.signal_level <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.reference_hz <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset reference: high first sample, back-to-back periods, then random tick gaps
    idle_on = 1'b0;
    run_measurement(0, 1, 3);
    run_measurement(1, 1, 1);
    run_measurement(3, 5, 2);
    run_measurement(2, 20, 25);
    idle_on = 1'b1;
    run_measurement(1, 2, 3);
    repeat (4) send_tick(1'b1);
    run_measurement(2, 1, 4);

    ref_vals[0] = 24'hFFFFFF;
    ref_vals[1] = '0;
    ref_vals[2] = 24'd1;
    ref_vals[3] = REF_WIDTH'($urandom_range(0, 24'hFFFFFF));
    ref_vals[4] = REF_WIDTH'($urandom_range(2, 2000));
    ref_vals[5] = REF_RESET;
    foreach (ref_vals[i]) begin
      settle();
      write_ref(ref_vals[i]);
      run_measurement(1, 1, 1);
      run_measurement(1, $urandom_range(1, 3), $urandom_range(1, 3));
      random_traffic(90, 4);
    end

    settle();
    if (errors == 0 && outstanding == 0) begin
      $display("input_capture_frequency_meter_top_tb: PASS");
    end else begin
      $display("input_capture_frequency_meter_top_tb: FAIL");
    end
    $finish;
  end

endmodule
